// ----- src/tss_pkg.sv -----
// tss_pkg: shared types and constants for the task signal scheduler
// operation and outcome codes, input and result word structs, default sizes
// no dependencies
package tss_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_TASK_SLOTS = 16;
    localparam int DEF_FLAG_BITS  = 32;

    // fixed field widths of the channel words
    localparam int TASK_ID_W = 4;
    localparam int SIG_W     = 32;

    // scheduling operations
    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_YIELD = 3'd1,
        OP_WAIT  = 3'd2,
        OP_SEND  = 3'd3,
        OP_TAKE  = 3'd4
    } t_op;

    // result outcome codes
    typedef enum logic [1:0] {
        OUT_DONE    = 2'd0,
        OUT_BLOCKED = 2'd1,
        OUT_NO_TASK = 2'd2,
        OUT_ALREADY = 2'd3
    } t_outcome;

    // input word
    typedef struct packed {
        t_op                  operation;
        logic [TASK_ID_W-1:0] task_id;
        logic [SIG_W-1:0]     signal_set;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [TASK_ID_W-1:0] running_task;
        logic                 idle;
        logic [SIG_W-1:0]     signals_out;
        t_outcome             outcome;
    } t_out_word;

endpackage

// ----- src/tss_task_store.sv -----
// tss_task_store: per-task memory holding the wait mask and received flags
// registered read with write-first forwarding, valid bits make unwritten entries read zero
// no package dependencies
module tss_task_store #(
    parameter int SLOTS  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [SLOTS];
    logic [DATA_W-1:0] r_rd_data;
    logic [SLOTS-1:0]  r_valid;
    logic              r_rd_hit;
    logic              fwd;

    // a read at the address being written returns the new entry
    assign fwd = i_wr_en && (i_wr_addr == i_rd_addr);

    // memory array and read data register
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            if (fwd) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    // written-entry tracking, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= fwd || r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

// ----- src/tss_ready_ring.sv -----
// tss_ready_ring: ring memory of ready task ids
// one write and one registered read per cycle, write-first on a shared address
// no package dependencies
module tss_ready_ring #(
    parameter int SLOTS  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [ADDR_W-1:0] i_wr_data,
    output logic [ADDR_W-1:0] o_rd_data
);

    logic [ADDR_W-1:0] r_mem [SLOTS];
    logic [ADDR_W-1:0] r_rd_data;

    // ring storage and registered head read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/task_signal_scheduler_core.sv -----
// task_signal_scheduler_core: event-flag task scheduler with a FIFO ready queue
// uses tss_pkg, tss_task_store and tss_ready_ring
// single pass between an input register and a result register
//
// One scheduling word is accepted every cycle while input stall is low, and it
// passes through the input and result registers: the accepting edge registers
// the word and starts the reads of the task flag memory and the ready ring
// head; the edge at which the word moves on applies the operation, writes the
// memories and loads the result register. The read addresses for a word come
// from the task and head values left by the word ahead of it, and both
// memories forward a write to a read at the same address, so back-to-back words
// see each other's updates. Input stall rises only while a word waits behind a
// stalled result. Task ids are reduced modulo TASK_SLOTS, flag bits at or above
// FLAG_BITS are ignored, and no clearing pass is needed after reset.
module task_signal_scheduler_core #(
    parameter int TASK_SLOTS = tss_pkg::DEF_TASK_SLOTS,
    parameter int FLAG_BITS  = tss_pkg::DEF_FLAG_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tss_pkg::t_in_word i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output tss_pkg::t_out_word o_out_data,
    input  logic              i_out_stall
);

    localparam int TASK_W  = $clog2(TASK_SLOTS);
    localparam int CNT_W   = $clog2(TASK_SLOTS + 1);
    localparam int SUM_W   = TASK_W + 1;
    localparam int ENTRY_W = 2 * FLAG_BITS;
    localparam int ID_W    = tss_pkg::TASK_ID_W;
    localparam int SIG_W   = tss_pkg::SIG_W;

    // input register
    logic                 r_in_valid;
    tss_pkg::t_op         r_op;
    logic [TASK_W-1:0]    r_id;
    logic [FLAG_BITS-1:0] r_set;

    // scheduler state
    logic [TASK_SLOTS-1:0] r_in_use;
    logic [TASK_SLOTS-1:0] r_waiting;
    logic [TASK_W-1:0]     r_head;
    logic [CNT_W-1:0]      r_cnt;
    logic [TASK_W-1:0]     r_cur;
    logic                  r_run;
    logic [TASK_W-1:0]     n_head;
    logic [CNT_W-1:0]      n_cnt;
    logic [TASK_W-1:0]     n_cur;
    logic                  n_run;

    // result register
    logic               r_out_valid;
    tss_pkg::t_out_word r_out;
    tss_pkg::t_out_word ex_word;

    // handshake
    logic accept;
    logic fire;

    // accept side
    logic [TASK_W-1:0] acc_id;
    logic              acc_uses_cur;
    logic [TASK_W-1:0] st_rd_addr;

    // memory ports
    logic [ENTRY_W-1:0] st_rd;
    logic               st_we;
    logic [TASK_W-1:0]  st_waddr;
    logic [ENTRY_W-1:0] st_wdata;
    logic [TASK_W-1:0]  ring_rd;
    logic               ring_we;
    logic [TASK_W-1:0]  ring_waddr;
    logic [TASK_W-1:0]  ring_wdata;

    // execute stage
    logic [FLAG_BITS-1:0] ex_flags;
    logic [FLAG_BITS-1:0] ex_mask;
    logic [FLAG_BITS-1:0] ex_match;
    logic [FLAG_BITS-1:0] ex_new_flags;
    logic [FLAG_BITS-1:0] ex_sig;
    logic [SUM_W-1:0]     ex_tail_sum;
    logic [TASK_W-1:0]    ex_tail;
    logic [TASK_W-1:0]    ex_head_dec;
    logic                 ex_full;
    logic                 ex_push_tail;
    logic                 ex_push_head;
    logic                 ex_set_in_use;
    logic                 ex_set_waiting;
    logic                 ex_clr_waiting;
    logic [TASK_W-1:0]    ex_pop_id;
    logic [TASK_W-1:0]    p_head;
    logic [CNT_W-1:0]     p_cnt;
    logic [TASK_W-1:0]    p_cur;
    logic                 p_run;
    tss_pkg::t_outcome    ex_outcome;

    // handshake: a word moves on unless the result register is held
    assign fire        = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // task id modulo slot count, as a small table
    always_comb begin
        acc_id = '0;
        for (int v = 0; v < (1 << ID_W); v++) begin
            if (i_in_data.task_id == ID_W'(v)) begin
                acc_id = TASK_W'(v % TASK_SLOTS);
            end
        end
    end

    // read address: running task or addressed task
    always_comb begin
        case (i_in_data.operation)
            tss_pkg::OP_YIELD,
            tss_pkg::OP_WAIT,
            tss_pkg::OP_TAKE: acc_uses_cur = 1'b1;
            default:          acc_uses_cur = 1'b0;
        endcase
        st_rd_addr = acc_uses_cur ? n_cur : acc_id;
    end

    tss_task_store #(
        .SLOTS  (TASK_SLOTS),
        .ADDR_W (TASK_W),
        .DATA_W (ENTRY_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (st_rd_addr),
        .i_wr_en   (st_we),
        .i_wr_addr (st_waddr),
        .i_wr_data (st_wdata),
        .o_rd_data (st_rd)
    );

    tss_ready_ring #(
        .SLOTS  (TASK_SLOTS),
        .ADDR_W (TASK_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (n_head),
        .i_wr_en   (ring_we),
        .i_wr_addr (ring_waddr),
        .i_wr_data (ring_wdata),
        .o_rd_data (ring_rd)
    );

    // operation, queue update and dispatch
    always_comb begin
        ex_flags     = st_rd[FLAG_BITS-1:0];
        ex_mask      = st_rd[ENTRY_W-1:FLAG_BITS];
        ex_match     = ex_flags & r_set;
        ex_new_flags = ex_flags | r_set;
        ex_tail_sum  = SUM_W'(r_head) + SUM_W'(r_cnt);
        ex_tail      = (ex_tail_sum >= SUM_W'(TASK_SLOTS))
                     ? TASK_W'(ex_tail_sum - SUM_W'(TASK_SLOTS))
                     : TASK_W'(ex_tail_sum);
        ex_head_dec  = (r_head == '0) ? TASK_W'(TASK_SLOTS - 1) : r_head - 1'b1;
        ex_full      = (r_cnt == CNT_W'(TASK_SLOTS));

        st_we          = 1'b0;
        st_wdata       = {ex_mask, ex_flags};
        ring_we        = 1'b0;
        ring_waddr     = ex_tail;
        ring_wdata     = r_id;
        ex_push_tail   = 1'b0;
        ex_push_head   = 1'b0;
        ex_set_in_use  = 1'b0;
        ex_set_waiting = 1'b0;
        ex_clr_waiting = 1'b0;
        ex_sig         = '0;
        ex_outcome     = tss_pkg::OUT_DONE;
        p_run          = r_run;
        p_head         = r_head;
        p_cnt          = r_cnt;
        p_cur          = r_cur;

        case (r_op)
            tss_pkg::OP_ADD: begin
                if (r_in_use[r_id]) begin
                    ex_outcome = tss_pkg::OUT_ALREADY;
                end else begin
                    ex_set_in_use = 1'b1;
                    ex_push_tail  = 1'b1;
                end
            end
            tss_pkg::OP_YIELD: begin
                if (!r_run) begin
                    ex_outcome = tss_pkg::OUT_NO_TASK;
                end else begin
                    ex_push_tail = 1'b1;
                    ring_wdata   = r_cur;
                    p_run        = 1'b0;
                end
            end
            tss_pkg::OP_WAIT: begin
                if (!r_run) begin
                    ex_outcome = tss_pkg::OUT_NO_TASK;
                end else if (ex_match != '0) begin
                    st_we    = 1'b1;
                    st_wdata = {ex_mask, ex_flags & ~r_set};
                    ex_sig   = ex_match;
                end else begin
                    st_we          = 1'b1;
                    st_wdata       = {r_set, ex_flags};
                    ex_set_waiting = 1'b1;
                    p_run          = 1'b0;
                    ex_outcome     = tss_pkg::OUT_BLOCKED;
                end
            end
            tss_pkg::OP_SEND: begin
                st_we    = 1'b1;
                st_wdata = {ex_mask, ex_new_flags};
                if (r_waiting[r_id] && ((ex_new_flags & ex_mask) != '0)) begin
                    ex_clr_waiting = 1'b1;
                    ex_push_head   = 1'b1;
                end
            end
            tss_pkg::OP_TAKE: begin
                if (!r_run) begin
                    ex_outcome = tss_pkg::OUT_NO_TASK;
                end else begin
                    st_we    = 1'b1;
                    st_wdata = {ex_mask, {FLAG_BITS{1'b0}}};
                    ex_sig   = ex_flags;
                end
            end
            default: begin
            end
        endcase

        // ready queue pushes
        if (ex_push_tail && !ex_full) begin
            ring_we    = 1'b1;
            ring_waddr = ex_tail;
            p_cnt      = r_cnt + 1'b1;
        end
        if (ex_push_head && !ex_full) begin
            ring_we    = 1'b1;
            ring_waddr = ex_head_dec;
            p_head     = ex_head_dec;
            p_cnt      = r_cnt + 1'b1;
        end

        // dispatch the queue head when nothing runs
        ex_pop_id = (ring_we && (ring_waddr == p_head)) ? ring_wdata : ring_rd;
        if (!p_run && (p_cnt != '0)) begin
            p_cur  = ex_pop_id;
            p_run  = 1'b1;
            p_head = (p_head == TASK_W'(TASK_SLOTS - 1)) ? '0 : p_head + 1'b1;
            p_cnt  = p_cnt - 1'b1;
        end

        // write address follows the read address chosen at accept
        case (r_op)
            tss_pkg::OP_YIELD,
            tss_pkg::OP_WAIT,
            tss_pkg::OP_TAKE: st_waddr = r_cur;
            default:          st_waddr = r_id;
        endcase

        // memory and flag writes only when the word moves on
        st_we   = st_we && fire;
        ring_we = ring_we && fire;

        ex_word.running_task = p_run ? ID_W'(p_cur) : '0;
        ex_word.idle         = !p_run;
        ex_word.signals_out  = SIG_W'(ex_sig);
        ex_word.outcome      = ex_outcome;

        n_head = fire ? p_head : r_head;
        n_cnt  = fire ? p_cnt : r_cnt;
        n_cur  = fire ? p_cur : r_cur;
        n_run  = fire ? p_run : r_run;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_use    <= '0;
            r_waiting   <= '0;
            r_head      <= '0;
            r_cnt       <= '0;
            r_cur       <= '0;
            r_run       <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (fire && ex_set_in_use) begin
                r_in_use[r_id] <= 1'b1;
            end
            if (fire && ex_set_waiting) begin
                r_waiting[r_cur] <= 1'b1;
            end
            if (fire && ex_clr_waiting) begin
                r_waiting[r_id] <= 1'b0;
            end
            r_head <= n_head;
            r_cnt  <= n_cnt;
            r_cur  <= n_cur;
            r_run  <= n_run;
        end
    end

    // input and result words
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_in_data.operation;
            r_id  <= acc_id;
            r_set <= FLAG_BITS'(i_in_data.signal_set);
        end
        if (fire) begin
            r_out <= ex_word;
        end
    end

    // queue never holds more than one entry per slot
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(TASK_SLOTS))
        else $error("ready count above slot count");

    // with nothing running the ready queue must be empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run |-> (r_cnt == '0))
        else $error("idle with ready tasks pending");

    // the running task was added and is not waiting
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_in_use[r_cur] && !r_waiting[r_cur]))
        else $error("running task is dormant or waiting");

    // a blocked result always comes with a new dispatch or idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (ex_outcome == tss_pkg::OUT_BLOCKED)) |=> (!r_run || (r_cnt < $past(r_cnt))
            || ($past(r_cnt) == '0)))
        else $error("blocked task left running");

endmodule
